// ----- rtl/pse_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package pse_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DATA_W      = 32;

  localparam logic [3:0] DIGIT_MAX = 4'd9;

  typedef enum logic [2:0] {
    CMD_DIGIT   = 3'd0,
    CMD_ADD     = 3'd1,
    CMD_SUB     = 3'd2,
    CMD_MUL     = 3'd3,
    CMD_DIV     = 3'd4,
    CMD_END     = 3'd5,
    CMD_INVALID = 3'd6
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_BAD_TOKEN     = 3'd1,
    ST_FEW_OPERANDS  = 3'd2,
    ST_DIV_ZERO      = 3'd3,
    ST_DEPTH_NOT_ONE = 3'd4,
    ST_OVERFLOW      = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_MUL = 2'd2,
    ALU_DIV = 2'd3
  } alu_op_e;

  typedef struct packed {
    logic [2:0] cmd;
    logic [3:0] digit;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [2:0]         status;
  } out_item_t;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] result;
  } alu_rsp_t;

  function automatic alu_op_e cmd_to_op(logic [2:0] cmd);
    alu_op_e op;
    case (cmd)
      CMD_ADD: op = ALU_ADD;
      CMD_SUB: op = ALU_SUB;
      CMD_MUL: op = ALU_MUL;
      default: op = ALU_DIV;
    endcase
    return op;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/pse_stack.sv -----
`timescale 1ns / 1ps
`default_nettype none
module pse_stack
  import pse_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [IDX_W-1:0]  waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic [IDX_W-1:0]  raddr_a_i,
  input  wire logic [IDX_W-1:0]  raddr_b_i,
  output logic      [DATA_W-1:0] rdata_a_o,
  output logic      [DATA_W-1:0] rdata_b_o
);

  logic [DATA_W-1:0] mem [STACK_DEPTH];

  // one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule
`default_nettype wire

// ----- rtl/pse_alu.sv -----
`timescale 1ns / 1ps
`default_nettype none
module pse_alu
  import pse_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire alu_req_t          req_i,
  input  wire logic [DATA_W-1:0] a_i,
  input  wire logic [DATA_W-1:0] b_i,
  output alu_rsp_t               rsp_o
);

  localparam int STEP_W = $clog2(DATA_W);

  logic              busy_q, busy_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [DATA_W-1:0] rem_q, rem_d;
  logic [DATA_W-1:0] quo_q, quo_d;
  logic [DATA_W-1:0] dmag_q, dmag_d;
  logic              neg_q, neg_d;
  logic              done_q, done_d;
  logic [DATA_W-1:0] res_q, res_d;

  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  logic [DATA_W-1:0] a_mag, b_mag;
  logic [DATA_W-1:0] prod;

  always_comb begin
    a_mag  = a_i[DATA_W-1] ? (DATA_W'(0) - a_i) : a_i;
    b_mag  = b_i[DATA_W-1] ? (DATA_W'(0) - b_i) : b_i;
    // only the low word of the product is kept
    prod   = a_i * b_i;
    trial  = {rem_q, quo_q[DATA_W-1]};
    diff   = trial - {1'b0, dmag_q};

    busy_d = busy_q;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dmag_d = dmag_q;
    neg_d  = neg_q;
    done_d = 1'b0;
    res_d  = res_q;

    if (busy_q) begin
      // one restoring step per cycle
      if (!diff[DATA_W]) begin
        rem_d = diff[DATA_W-1:0];
      end else begin
        rem_d = trial[DATA_W-1:0];
      end
      quo_d  = {quo_q[DATA_W-2:0], ~diff[DATA_W]};
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(DATA_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        res_d  = neg_q ? (DATA_W'(0) - quo_d) : quo_d;
      end
    end else if (req_i.start) begin
      case (req_i.op)
        ALU_ADD: begin
          res_d  = b_i + a_i;
          done_d = 1'b1;
        end
        ALU_SUB: begin
          res_d  = b_i - a_i;
          done_d = 1'b1;
        end
        ALU_MUL: begin
          res_d  = prod;
          done_d = 1'b1;
        end
        default: begin
          // b / a on magnitudes, sign fixed at the end
          busy_d = 1'b1;
          step_d = '0;
          rem_d  = '0;
          quo_d  = b_mag;
          dmag_d = a_mag;
          neg_d  = a_i[DATA_W-1] ^ b_i[DATA_W-1];
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    dmag_q <= dmag_d;
    neg_q  <= neg_d;
    res_q  <= res_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;

endmodule
`default_nettype wire

// ----- rtl/postfix_stack_evaluator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Postfix expression evaluator. Each input transfer carries one token; digits are
// pushed onto a 32-entry operand stack, operators pop two operands and push the
// result, and an end token produces one output transfer holding the final value
// (or the first error, with value zero) and then empties the stack. Digit and
// bad tokens are handled in the idle state, as are tokens ignored after an error.
// Add, subtract and multiply read the two top entries from the stack memory, pass
// them through the shared arithmetic unit in an execute state and write the result
// back in a wait state. Divide waits there while the radix-2 divider in that unit
// runs (one quotient bit a cycle). An end token waits until the output register is
// free. The input is not ready while a token is being worked on; a waiting result
// does not block digit or operator tokens.
module postfix_stack_evaluator
  import pse_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_data_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WAIT,
    S_END
  } state_e;

  state_e            state_q;
  logic [CNT_W-1:0]  count_q;
  status_e           err_q;
  alu_op_e           op_q;
  logic              out_valid_q;
  out_item_t         out_data_q;

  logic              in_xfer;
  logic              out_free;
  logic [CNT_W-1:0]  cnt_m1, cnt_m2;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [DATA_W-1:0] opa, opb;
  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;
  logic              div_zero;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign cnt_m1      = count_q - CNT_W'(1);
  assign cnt_m2      = count_q - CNT_W'(2);
  assign div_zero    = (op_q == ALU_DIV) && (opa == '0);

  // Top of stack is always being read, so operands are ready in the cycle
  // after the token transfer. With a depth of one, the top is entry zero.
  pse_stack u_stack (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (cnt_m1[IDX_W-1:0]),
    .raddr_b_i (cnt_m2[IDX_W-1:0]),
    .rdata_a_o (opa),
    .rdata_b_o (opb)
  );

  assign alu_req.start = (state_q == S_EXEC) && !div_zero;
  assign alu_req.op    = op_q;

  pse_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .a_i    (opa),
    .b_i    (opb),
    .rsp_o  (alu_rsp)
  );

  // Stack write: push a good digit, or replace the second entry with the result.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count_q[IDX_W-1:0];
    mem_wdata = DATA_W'(in_data_i.digit);
    if (state_q == S_WAIT) begin
      mem_we    = alu_rsp.done;
      mem_waddr = cnt_m2[IDX_W-1:0];
      mem_wdata = alu_rsp.result;
    end else if (in_xfer && err_q == ST_OK && in_data_i.cmd == CMD_DIGIT
                 && in_data_i.digit <= DIGIT_MAX
                 && count_q != CNT_W'(STACK_DEPTH)) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      err_q       <= ST_OK;
      op_q        <= ALU_ADD;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      // drop the result once the sink takes it; a finishing end token refills it
      if (out_valid_q && out_ready_i && state_q != S_END) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            if (in_data_i.cmd == CMD_END) begin
              state_q <= S_END;
            end else if (err_q == ST_OK) begin
              // tokens after an error are ignored until the end token
              unique case (in_data_i.cmd) inside
                CMD_DIGIT: begin
                  if (in_data_i.digit > DIGIT_MAX) begin
                    err_q <= ST_BAD_TOKEN;
                  end else if (count_q == CNT_W'(STACK_DEPTH)) begin
                    err_q <= ST_OVERFLOW;
                  end else begin
                    count_q <= count_q + CNT_W'(1);
                  end
                end
                CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
                  if (count_q < CNT_W'(2)) begin
                    err_q <= ST_FEW_OPERANDS;
                  end else begin
                    op_q    <= cmd_to_op(in_data_i.cmd);
                    state_q <= S_EXEC;
                  end
                end
                default: begin
                  err_q <= ST_BAD_TOKEN;
                end
              endcase
            end
          end
        end
        S_EXEC: begin
          // divide by zero leaves the stack as it is
          if (div_zero) begin
            err_q   <= ST_DIV_ZERO;
            state_q <= S_IDLE;
          end else begin
            state_q <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (alu_rsp.done) begin
            count_q <= cnt_m1;
            state_q <= S_IDLE;
          end
        end
        S_END: begin
          // hold until the output register is free
          if (out_free) begin
            out_valid_q <= 1'b1;
            if (err_q != ST_OK) begin
              out_data_q.status <= err_q;
              out_data_q.value  <= '0;
            end else if (count_q == CNT_W'(1)) begin
              out_data_q.status <= ST_OK;
              out_data_q.value  <= opa;
            end else begin
              out_data_q.status <= ST_DEPTH_NOT_ONE;
              out_data_q.value  <= '0;
            end
            count_q <= '0;
            err_q   <= ST_OK;
            state_q <= S_IDLE;
          end else if (out_valid_q && out_ready_i) begin
            out_valid_q <= 1'b0;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Stack never holds more than its depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(STACK_DEPTH))
    else $error("operand count above stack depth");

  // The arithmetic unit only answers while the sequencer waits for it.
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_rsp.done |-> state_q == S_WAIT)
    else $error("arithmetic result outside wait state");

  // No stack write once an error is latched.
  a_no_write_on_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> err_q == ST_OK)
    else $error("stack written after error");

  // Ending an expression empties the stack and clears the error.
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_END && out_free) |=> count_q == '0 && err_q == ST_OK && out_valid_q)
    else $error("end token did not reset evaluator state");

endmodule
`default_nettype wire
